FILE: design/fdrl_pkg.sv
package fdrl_pkg;

    // Width of the capacity register and of the entry count on the results.
    localparam int CAP_W = 5;

    // Capacity after reset.
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Control lines that the sequencer hands to every cell of the chain.
    typedef struct packed {
        logic insert;   // shift towards the old end, new identifier at cell 0
        logic drain;    // shift towards cell 0 while the list is read out
    } fdrl_cell_ctrl_t;

    // Sequencer states.
    typedef enum logic {
        ST_COLLECT,
        ST_DUMP
    } fdrl_state_t;

endpackage

FILE: design/fdrl_cell.sv
module fdrl_cell
    import fdrl_pkg::*;
#(
    parameter int ID_WIDTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  fdrl_cell_ctrl_t     ctrl,
    input  logic                keep,       // this position lies within the capacity
    input  logic [ID_WIDTH-1:0] probe_id,
    input  logic [ID_WIDTH-1:0] newer_id,
    input  logic                newer_vld,
    input  logic [ID_WIDTH-1:0] older_id,
    input  logic                older_vld,
    output logic [ID_WIDTH-1:0] id,
    output logic                vld,
    output logic                hit
);

    logic [ID_WIDTH-1:0] id_reg;
    logic [ID_WIDTH-1:0] id_next;
    logic                vld_reg;
    logic                vld_next;

    // Take the newer neighbour on an insert, the older one while draining.
    always_comb begin
        id_next  = id_reg;
        vld_next = vld_reg;
        if (ctrl.insert) begin
            id_next  = newer_id;
            vld_next = newer_vld & keep;
        end else if (ctrl.drain) begin
            id_next  = older_id;
            vld_next = older_vld;
        end
    end

    // The valid flag is control state; the identifier needs no reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg <= id_next;
    end

    // Membership compare for this position.
    assign hit = vld_reg && (id_reg == probe_id);
    assign id  = id_reg;
    assign vld = vld_reg;

endmodule

FILE: design/fifo_dedup_recent_list.sv
// Recent list of distinct identifiers with first-in first-out replacement.
// The input stream (s_axis_*) offers one identifier per request. When it is
// not yet held it enters as the newest entry; when the list is then over the
// configured capacity the oldest entries drop off. A repeat changes nothing.
// A non-final request gives no result, so one identifier can be accepted
// every clock while no dump is under way.
// The request with tlast set is handled the same way and then starts a dump:
// from the next cycle the output stream (m_axis_*) presents every held entry,
// newest first, one per cycle while m_axis_tready is high. Each result
// carries the entry count; tlast marks the oldest entry. After the last
// result is taken the list is empty and s_axis_tready returns high.
// No input is taken during a dump; a stall simply holds the current result.
// The list is a chain of cells that shift one place per insert or per
// delivered result; a parallel compare across the cells finds repeats.
// Synchronous reset empties the list and sets the capacity to sixteen.
// The user must write capacity via cfg_wr_en/cfg_wr_data while the block is
// idle; the block does not enforce it. Zero acts as one; values above the depth act as the depth.
module fifo_dedup_recent_list
    import fdrl_pkg::*;
#(
    parameter int DEPTH    = 16,
    parameter int ID_WIDTH = 32,
    localparam int S_DATA_W = ((ID_WIDTH + 7) / 8) * 8,
    localparam int M_DATA_W = ((ID_WIDTH + CAP_W + 7) / 8) * 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // Capacity register.
    input  logic                      cfg_wr_en,
    input  logic [CAP_W-1:0]          cfg_wr_data,
    // Input stream. tdata: message_id. tlast: final_item.
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [S_DATA_W-1:0]       s_axis_tdata,
    input  logic                      s_axis_tlast,
    // Result stream. tdata: entry_id, then shown_count. tlast: end_of_list.
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [M_DATA_W-1:0]       m_axis_tdata,
    output logic                      m_axis_tlast
);

    localparam int CAP_LIM  = (DEPTH > 31) ? 31 : DEPTH;
    localparam logic [CAP_W-1:0] DEPTH_CAP = CAP_W'(CAP_LIM);

    fdrl_state_t         state_reg;
    fdrl_state_t         state_next;
    logic [CAP_W-1:0]    cap_reg;
    logic [CAP_W-1:0]    cap_next;
    logic [CAP_W-1:0]    held_reg;
    logic [CAP_W-1:0]    held_next;
    logic [CAP_W-1:0]    cap_eff;
    fdrl_cell_ctrl_t     cell_ctrl;
    logic                s_accept;
    logic                m_accept;
    logic                hit_any;
    logic [ID_WIDTH-1:0] new_id;

    logic [ID_WIDTH-1:0] cell_id  [0:DEPTH];
    logic                cell_vld [0:DEPTH];
    logic [DEPTH-1:0]    hit_vec;
    logic [DEPTH-1:0]    vld_vec;

    assign new_id   = s_axis_tdata[ID_WIDTH-1:0];
    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign m_accept = m_axis_tvalid && m_axis_tready;
    assign hit_any  = |hit_vec;

    // Capacity register and its clamped value.
    always_comb begin
        cap_next = cap_reg;
        if (cfg_wr_en) begin
            cap_next = cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else begin
            cap_reg <= cap_next;
        end
    end

    always_comb begin
        cap_eff = cap_reg;
        if (cap_reg == '0) begin
            cap_eff = CAP_W'(1);
        end else if (cap_reg > DEPTH_CAP) begin
            cap_eff = DEPTH_CAP;
        end
    end

    // Sequencer: next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_COLLECT: begin
                if (s_accept && s_axis_tlast) begin
                    state_next = ST_DUMP;
                end
            end
            ST_DUMP: begin
                if (m_accept && m_axis_tlast) begin
                    state_next = ST_COLLECT;
                end
            end
            default: state_next = ST_COLLECT;
        endcase
    end

    // Sequencer: outputs and cell control.
    always_comb begin
        s_axis_tready    = 1'b0;
        m_axis_tvalid    = 1'b0;
        cell_ctrl.insert = 1'b0;
        cell_ctrl.drain  = 1'b0;
        unique case (state_reg)
            ST_COLLECT: begin
                s_axis_tready    = 1'b1;
                cell_ctrl.insert = s_axis_tvalid && !hit_any;
            end
            ST_DUMP: begin
                m_axis_tvalid   = 1'b1;
                cell_ctrl.drain = m_axis_tready;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_COLLECT;
        end else begin
            state_reg <= state_next;
        end
    end

    // Entry count: on an insert grows by one or, at or past the capacity, takes the capacity; clears after a dump.
    always_comb begin
        held_next = held_reg;
        if (cell_ctrl.insert) begin
            held_next = (held_reg >= cap_eff) ? cap_eff : held_reg + CAP_W'(1);
        end else if (m_accept && m_axis_tlast) begin
            held_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
        end else begin
            held_reg <= held_next;
        end
    end

    // Chain of cells, newest at position zero; the far end reads as empty.
    assign cell_id[DEPTH]  = '0;
    assign cell_vld[DEPTH] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [ID_WIDTH-1:0] newer_id;
        logic                newer_vld;
        logic                keep;

        if (i == 0) begin : g_head
            assign newer_id  = new_id;
            assign newer_vld = 1'b1;
        end else begin : g_body
            assign newer_id  = cell_id[i-1];
            assign newer_vld = cell_vld[i-1];
        end

        assign keep = 32'(i) < 32'(cap_eff);

        fdrl_cell #(
            .ID_WIDTH (ID_WIDTH)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (cell_ctrl),
            .keep      (keep),
            .probe_id  (new_id),
            .newer_id  (newer_id),
            .newer_vld (newer_vld),
            .older_id  (cell_id[i+1]),
            .older_vld (cell_vld[i+1]),
            .id        (cell_id[i]),
            .vld       (cell_vld[i]),
            .hit       (hit_vec[i])
        );

        assign vld_vec[i] = cell_vld[i];
    end

    // Results come straight from the head cell.
    assign m_axis_tdata = M_DATA_W'({held_reg, cell_id[0]});
    assign m_axis_tlast = !cell_vld[1];

`ifndef SYNTHESIS
    // The occupied cells always match the entry count outside a dump.
    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_COLLECT |-> $countones(vld_vec) == int'(held_reg))
        else $error("occupied cells differ from entry count");

    // A result is only offered from an occupied head cell.
    a_head_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> cell_vld[0])
        else $error("result offered from an empty head cell");

    // Taking the last result leaves the list empty and ready for input.
    a_dump_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        m_accept && m_axis_tlast |=> s_axis_tready && !cell_vld[0] && held_reg == '0)
        else $error("list not empty after the last result");

    // A non-final repeat never changes the list.
    a_repeat_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && hit_any && !s_axis_tlast |=> $stable(held_reg) && $stable(vld_vec))
        else $error("repeated identifier changed the list");
`endif

endmodule

FILE: tb/tb_fifo_dedup_recent_list.sv
module tb_fifo_dedup_recent_list
    import fdrl_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ID_W     = 32;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 40;
    localparam int LIST_MAX = 16;

    // One offered identifier and one expected entry of a dump.
    typedef struct {
        logic [ID_W-1:0] message_id;
        logic            final_item;
    } offer_t;

    typedef struct {
        logic [ID_W-1:0]  entry_id;
        logic [CAP_W-1:0] shown_count;
        logic             end_of_list;
    } list_entry_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [CAP_W-1:0]    cfg_wr_data = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata = '0;    // message_id
    logic                s_axis_tlast = 1'b0;  // final_item
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;         // entry_id, shown_count
    logic                m_axis_tlast;         // end_of_list

    // Stimulus and the predicted dump contents.
    offer_t          offer_queue[$];
    list_entry_t     dump_queue[$];
    logic [ID_W-1:0] held_ids[$];    // oldest first
    logic [CAP_W-1:0] list_capacity = CAP_RESET;

    int unsigned offered_total  = 0;
    int unsigned accepted_total = 0;
    int unsigned error_count    = 0;
    int unsigned send_idle_pct  = 22;
    int unsigned recv_idle_pct  = 61;

    offer_t      cur_offer;
    list_entry_t got_entry;
    list_entry_t want_entry;

    fifo_dedup_recent_list DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 aclk = ~aclk;

    // Zero acts as one and anything above the depth acts as the depth.
    function automatic int unsigned usable_capacity();
        int unsigned c;
        c = list_capacity;
        if (c == 0) c = 1;
        if (c > LIST_MAX) c = LIST_MAX;
        return c;
    endfunction

    // Apply one accepted request to the recent list and queue any dump it causes.
    task automatic absorb_request(input offer_t req);
        bit          seen;
        int unsigned cap;
        int unsigned n;
        list_entry_t e;
        seen = 1'b0;
        foreach (held_ids[i]) begin
            if (held_ids[i] == req.message_id) seen = 1'b1;
        end
        if (!seen) begin
            cap = usable_capacity();
            while (held_ids.size() >= cap) void'(held_ids.pop_front());
            held_ids.push_back(req.message_id);
        end
        if (req.final_item) begin
            n = held_ids.size();
            for (int k = 0; k < n; k++) begin
                e.entry_id    = held_ids[n - 1 - k];
                e.shown_count = CAP_W'(n);
                e.end_of_list = (k == n - 1);
                dump_queue.push_back(e);
            end
            held_ids.delete();
        end
    endtask

    // Request driver: holds a request until it is taken, then maybe idles.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                absorb_request(cur_offer);
                accepted_total++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (offer_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_offer = offer_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= cur_offer.message_id;
                    s_axis_tlast  <= cur_offer.final_item;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares each taken entry with the oldest prediction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_entry.entry_id    = m_axis_tdata[ID_W-1:0];
                got_entry.shown_count = m_axis_tdata[ID_W +: CAP_W];
                got_entry.end_of_list = m_axis_tlast;
                if (dump_queue.size() == 0) begin
                    $error("unexpected result: entry_id %h shown_count %0d end_of_list %0b",
                           got_entry.entry_id, got_entry.shown_count, got_entry.end_of_list);
                    error_count++;
                end else begin
                    want_entry = dump_queue.pop_front();
                    if (got_entry.entry_id !== want_entry.entry_id) begin
                        $error("entry_id: expected %h, actual %h",
                               want_entry.entry_id, got_entry.entry_id);
                        error_count++;
                    end
                    if (got_entry.shown_count !== want_entry.shown_count) begin
                        $error("shown_count: expected %0d, actual %0d",
                               want_entry.shown_count, got_entry.shown_count);
                        error_count++;
                    end
                    if (got_entry.end_of_list !== want_entry.end_of_list) begin
                        $error("end_of_list: expected %0b, actual %0b",
                               want_entry.end_of_list, got_entry.end_of_list);
                        error_count++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic offer(input logic [ID_W-1:0] id, input logic last);
        offer_t r;
        r.message_id = id;
        r.final_item = last;
        offer_queue.push_back(r);
        offered_total++;
    endtask

    // Wait until every request is taken and every dump entry delivered; a
    // non-final request leaves no result, so it counts as done once taken.
    task automatic wait_until_idle();
        while (accepted_total != offered_total || dump_queue.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en     <= 1'b1;
        cfg_wr_data   <= value;
        list_capacity = value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [CAP_W-1:0] pick_capacity();
        case ($urandom_range(5))
            0:       return 5'd0;
            1:       return 5'd1;
            2:       return 5'd16;
            3:       return 5'd31;
            default: return CAP_W'($urandom_range(31));
        endcase
    endfunction

    // Stimulus: directed lists first, then random lists in three idling phases.
    initial begin
        logic [ID_W-1:0] pool[32];
        logic [ID_W-1:0] id;
        int unsigned     pool_size;
        int unsigned     list_len;
        int unsigned     split;
        int unsigned     phase_items;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        write_capacity(CAP_RESET);

        // Extreme identifiers, a repeat, and a final request that is a repeat.
        offer(32'h0000_0000, 1'b0);
        offer(32'hFFFF_FFFF, 1'b0);
        offer(32'h0000_0000, 1'b0);
        offer(32'hFFFF_FFFF, 1'b1);

        // Seventeen distinct identifiers overflow a full list of sixteen.
        for (int i = 0; i < 17; i++)
            offer(32'hA5A5_0000 + ID_W'(i) * 32'h0101_0101, i == 16);

        // Capacity lowered below the held count, then a repeat of a held entry.
        offer(32'h1111_1111, 1'b0);
        offer(32'h2222_2222, 1'b0);
        offer(32'h3333_3333, 1'b0);
        offer(32'h4444_4444, 1'b0);
        wait_until_idle();
        write_capacity(5'd2);
        offer(32'h1111_1111, 1'b1);

        for (int phase = 0; phase < 3; phase++) begin
            wait_until_idle();
            case (phase)
                0:       begin send_idle_pct = 22; recv_idle_pct = 61; end
                1:       begin send_idle_pct = 61; recv_idle_pct = 22; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            phase_items = 0;
            while (phase_items < 95) begin
                if ($urandom_range(3) == 0) begin
                    wait_until_idle();
                    write_capacity(pick_capacity());
                end
                list_len  = ($urandom_range(7) == 0) ? $urandom_range(16, 30)
                                                     : $urandom_range(1, 10);
                pool_size = $urandom_range(1, 20);
                for (int i = 0; i < pool_size; i++) pool[i] = $urandom;
                split = (list_len > 1 && $urandom_range(4) == 0) ?
                        $urandom_range(1, list_len - 1) : 0;
                for (int k = 0; k < list_len; k++) begin
                    // Sometimes change the capacity in the middle of a list.
                    if (split != 0 && k == split) begin
                        wait_until_idle();
                        write_capacity(pick_capacity());
                    end
                    case ($urandom_range(9))
                        0:       id = $urandom;
                        1:       id = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
                        default: id = pool[$urandom_range(pool_size - 1)];
                    endcase
                    offer(id, k == list_len - 1);
                end
                phase_items += list_len;
            end
        end

        wait_until_idle();
        repeat (20) @(posedge aclk);
        if (error_count == 0 && dump_queue.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
